@@ rtl/core/bpsl_pkg.sv @@
// Shared types and constants of the balance controller core.
`default_nettype none

package bpsl_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ANGLE_GAIN_P   = 3'd0,
    CFG_ANGLE_GAIN_I   = 3'd1,
    CFG_ANGLE_GAIN_D   = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_SPEED_GAIN_P   = 3'd4,
    CFG_SPEED_GAIN_I   = 3'd5
  } cfg_idx_e;

  // Multiplier operand A selection.
  typedef enum logic [2:0] {
    A_ANGLE_GAIN_I,
    A_SPEED_GAIN_I,
    A_ANGLE_GAIN_P,
    A_ANGLE_GAIN_D,
    A_SPEED_GAIN_P,
    A_PRODUCT,
    A_EFFORT_SUM
  } a_sel_e;

  // Multiplier operand B selection.
  typedef enum logic [2:0] {
    B_ANGLE_ERR_SUM,
    B_SPEED_ERR_SUM,
    B_TIME_STEP,
    B_ANGLE_ERR,
    B_RATE_ERR,
    B_SPEED_ERR
  } b_sel_e;

  // What the datapath does with the registered product this cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ANGLE_INT,
    OP_SPEED_INT,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_EFFORT,
    OP_COMMAND
  } op_e;

  typedef struct packed {
    logic   load;
    logic   mul_en;
    a_sel_e a_sel;
    b_sel_e b_sel;
    op_e    op;
  } dp_cmd_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

endpackage

`default_nettype wire

@@ rtl/core/bpsl_datapath.sv @@
// Datapath of the balance controller: registers, shared multiplier and accumulators.
`default_nettype none

module bpsl_datapath
  import bpsl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire dp_cmd_t             cmd_i,
  input  wire logic [15:0]         tilt_angle_i,
  input  wire logic [15:0]         tilt_rate_i,
  input  wire logic [15:0]         wheel_speed_i,
  input  wire logic [15:0]         time_step_i,
  output logic [31:0]              motor_command_o
);

  localparam logic signed [51:0] RndAngle = 52'sd1 <<< 20;
  localparam logic signed [51:0] RndCmd   = 52'sd1 <<< 16;
  localparam logic signed [39:0] SatMax   = 40'sh007FFFFFFF;
  localparam logic signed [39:0] SatMin   = -40'sh0080000000;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > SatMax) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SatMin) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] gain_ap_q, gain_ai_q, gain_ad_q, gain_sp_q, gain_si_q;
  logic [30:0] limit_q;

  // Latched tick inputs.
  logic [15:0] err_q, serr_q, dt_q;
  logic [16:0] derr_q;
  logic [15:0] err_d, serr_d;
  logic [16:0] derr_d;

  // Controller state of the model.
  logic [15:0] last_err_q, last_serr_q;
  logic [31:0] ang_int_q, spd_int_q, last_eff_q, eff_q, cmd_acc_q;
  logic [39:0] acc_q;
  logic signed [51:0] prod_q;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod_d;
  logic [16:0] esum_a, esum_s;
  logic [32:0] esum_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_ap_q <= '0;
      gain_ai_q <= '0;
      gain_ad_q <= '0;
      limit_q   <= '0;
      gain_sp_q <= '0;
      gain_si_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ANGLE_GAIN_P:   gain_ap_q <= cfg_data_i[15:0];
        CFG_ANGLE_GAIN_I:   gain_ai_q <= cfg_data_i[15:0];
        CFG_ANGLE_GAIN_D:   gain_ad_q <= cfg_data_i[15:0];
        CFG_INTEGRAL_LIMIT: limit_q   <= cfg_data_i[30:0];
        CFG_SPEED_GAIN_P:   gain_sp_q <= cfg_data_i[15:0];
        CFG_SPEED_GAIN_I:   gain_si_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Errors are negated measurements; angle and speed saturate at full scale, rate widens.
  assign err_d  = (tilt_angle_i == 16'h8000) ? 16'h7FFF : 16'(-tilt_angle_i);
  assign serr_d = (wheel_speed_i == 16'h8000) ? 16'h7FFF : 16'(-wheel_speed_i);
  assign derr_d = 17'd0 - {tilt_rate_i[15], tilt_rate_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q  <= err_d;
      serr_q <= serr_d;
      derr_q <= derr_d;
      dt_q   <= time_step_i;
    end
  end

  assign esum_a = {last_err_q[15], last_err_q} + {err_q[15], err_q};
  assign esum_s = {last_serr_q[15], last_serr_q} + {serr_q[15], serr_q};
  assign esum_e = {last_eff_q[31], last_eff_q} + {eff_q[31], eff_q};

  always_comb begin
    case (cmd_i.a_sel)
      A_ANGLE_GAIN_I: mul_a = {{18{gain_ai_q[15]}}, gain_ai_q};
      A_SPEED_GAIN_I: mul_a = {{18{gain_si_q[15]}}, gain_si_q};
      A_ANGLE_GAIN_P: mul_a = {{18{gain_ap_q[15]}}, gain_ap_q};
      A_ANGLE_GAIN_D: mul_a = {{18{gain_ad_q[15]}}, gain_ad_q};
      A_SPEED_GAIN_P: mul_a = {{18{gain_sp_q[15]}}, gain_sp_q};
      A_PRODUCT:      mul_a = prod_q[33:0];
      A_EFFORT_SUM:   mul_a = {esum_e[32], esum_e};
      default:        mul_a = '0;
    endcase
    case (cmd_i.b_sel)
      B_ANGLE_ERR_SUM: mul_b = {esum_a[16], esum_a};
      B_SPEED_ERR_SUM: mul_b = {esum_s[16], esum_s};
      B_TIME_STEP:     mul_b = {2'b00, dt_q};
      B_ANGLE_ERR:     mul_b = {{2{err_q[15]}}, err_q};
      B_RATE_ERR:      mul_b = {derr_q[16], derr_q};
      B_SPEED_ERR:     mul_b = {{2{serr_q[15]}}, serr_q};
      default:         mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Post-processing of the registered product.
  logic signed [51:0] rnd_a, rnd_c;
  logic [30:0] inc_a;
  logic [34:0] inc_c;
  logic signed [32:0] aint_sum, sint_sum, lim_pos, lim_neg;
  logic [31:0] aint_new;
  logic signed [39:0] eff_sum, cmd_sum;

  assign rnd_a    = prod_q + RndAngle;
  assign inc_a    = rnd_a[51:21];
  assign aint_sum = {ang_int_q[31], ang_int_q} + {{2{inc_a[30]}}, inc_a};
  assign sint_sum = {spd_int_q[31], spd_int_q} + {{2{inc_a[30]}}, inc_a};
  assign lim_pos  = {2'b00, limit_q};
  assign lim_neg  = 33'd0 - {2'b00, limit_q};

  // The limit never exceeds the 32-bit range, so clamping the unsaturated sum
  // gives the same result as saturating first.
  always_comb begin
    if (aint_sum > lim_pos) begin
      aint_new = lim_pos[31:0];
    end else if (aint_sum < lim_neg) begin
      aint_new = lim_neg[31:0];
    end else begin
      aint_new = aint_sum[31:0];
    end
  end

  assign eff_sum = acc_q + {{4{ang_int_q[31]}}, ang_int_q, 4'b0000}
                 + {{4{spd_int_q[31]}}, spd_int_q, 4'b0000} + 40'sd8;
  assign rnd_c   = prod_q + RndCmd;
  assign inc_c   = rnd_c[51:17];
  assign cmd_sum = {{8{cmd_acc_q[31]}}, cmd_acc_q} + {{5{inc_c[34]}}, inc_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      last_serr_q <= '0;
      ang_int_q   <= '0;
      spd_int_q   <= '0;
      last_eff_q  <= '0;
      eff_q       <= '0;
      cmd_acc_q   <= '0;
      acc_q       <= '0;
    end else begin
      case (cmd_i.op)
        OP_ANGLE_INT: ang_int_q <= aint_new;
        OP_SPEED_INT: spd_int_q <= sat32({{7{sint_sum[32]}}, sint_sum});
        OP_ACC_LOAD:  acc_q <= prod_q[39:0];
        OP_ACC_ADD:   acc_q <= acc_q + prod_q[39:0];
        OP_EFFORT:    eff_q <= sat32({{4{eff_sum[39]}}, eff_sum[39:4]});
        OP_COMMAND: begin
          cmd_acc_q   <= sat32(cmd_sum);
          last_eff_q  <= eff_q;
          last_err_q  <= err_q;
          last_serr_q <= serr_q;
        end
        default: ;
      endcase
    end
  end

  assign motor_command_o = cmd_acc_q;

endmodule

`default_nettype wire

@@ rtl/core/bpsl_ctrl.sv @@
// Sequencing state machine of the balance controller.
`default_nettype none

module bpsl_ctrl
  import bpsl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output dp_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_GAIN,
    ST_ANG_DT,
    ST_SPD_GAIN,
    ST_SPD_DT,
    ST_P_TERM,
    ST_D_TERM,
    ST_SP_TERM,
    ST_SUM,
    ST_EFFORT,
    ST_CMD_DT,
    ST_CMD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o       = '{load: 1'b0, mul_en: 1'b0, a_sel: A_PRODUCT,
                    b_sel: B_TIME_STEP, op: OP_NONE};
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ANG_GAIN;
        end
      end
      ST_ANG_GAIN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = A_ANGLE_GAIN_I;
        cmd_o.b_sel  = B_ANGLE_ERR_SUM;
        state_d      = ST_ANG_DT;
      end
      ST_ANG_DT: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SPD_GAIN;
      end
      ST_SPD_GAIN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = A_SPEED_GAIN_I;
        cmd_o.b_sel  = B_SPEED_ERR_SUM;
        cmd_o.op     = OP_ANGLE_INT;
        state_d      = ST_SPD_DT;
      end
      ST_SPD_DT: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_P_TERM;
      end
      ST_P_TERM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = A_ANGLE_GAIN_P;
        cmd_o.b_sel  = B_ANGLE_ERR;
        cmd_o.op     = OP_SPEED_INT;
        state_d      = ST_D_TERM;
      end
      ST_D_TERM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = A_ANGLE_GAIN_D;
        cmd_o.b_sel  = B_RATE_ERR;
        cmd_o.op     = OP_ACC_LOAD;
        state_d      = ST_SP_TERM;
      end
      ST_SP_TERM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = A_SPEED_GAIN_P;
        cmd_o.b_sel  = B_SPEED_ERR;
        cmd_o.op     = OP_ACC_ADD;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_ACC_ADD;
        state_d  = ST_EFFORT;
      end
      ST_EFFORT: begin
        cmd_o.op = OP_EFFORT;
        state_d  = ST_CMD_DT;
      end
      ST_CMD_DT: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = A_EFFORT_SUM;
        state_d      = ST_CMD;
      end
      ST_CMD: begin
        // The command register is also the output register, so it only
        // moves once the previous word has left.
        if (slot_free) begin
          cmd_o.op    = OP_COMMAND;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ANG_GAIN))
    else $error("accepted word did not start the sequence");

  a_valid_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_CMD))
    else $error("result raised outside the command step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_COMMAND) |-> (!out_valid_q || out_ready_i))
    else $error("command updated while a result was still pending");

endmodule

`default_nettype wire

@@ rtl/core/balance_pid_with_speed_loop_core.sv @@
// Top level of the balance controller with PID angle loop and PI speed loop.
//
// Usage:
// The slave stream takes one word per control tick. Its tdata holds, from
// the lowest bit up, tilt_angle [15:0], tilt_rate [31:16], wheel_speed
// [47:32] and time_step [63:48]. The master stream returns one word per
// tick, the saturated motor command in Q15.16.
// Gains and the integral limit are written through the configuration
// channel (index plus data), which is always ready; writes to indexes past
// the last register are dropped. Writes are expected only while the core
// is idle.
// Operation: the core handles one tick at a time on a single shared
// 34x18 multiplier. The core returns to idle and can accept the next word
// in the same cycle in which the result becomes valid, once the final
// command step is no longer held by a waiting result.
// The command register doubles as the output register: a waiting result
// does not block acceptance of the next word, but the final command update
// of that next tick waits until the receiver has taken the old result.
// Reset clears all gains, the limit, the integrators and the command.
`default_nettype none

module balance_pid_with_speed_loop_core
  import bpsl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write channel.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Input stream.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tilt_angle[15:0], tilt_rate[31:16], wheel_speed[47:32], time_step[63:48]
  input  wire logic [63:0]         s_axis_tdata,
  // Output stream.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // motor_command[31:0]
  output logic [31:0]              m_axis_tdata
);

  dp_cmd_t cmd;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  bpsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bpsl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .tilt_angle_i    (s_axis_tdata[15:0]),
    .tilt_rate_i     (s_axis_tdata[31:16]),
    .wheel_speed_i   (s_axis_tdata[47:32]),
    .time_step_i     (s_axis_tdata[63:48]),
    .motor_command_o (m_axis_tdata)
  );

endmodule

`default_nettype wire
